// ----- rtl/core/stt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the software timer table
// Operation and result codes, option bits, and the transaction token that
// walks down the row of timer cells.
// ----------------------------------------------------------------------------
package stt_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_START  = 3'd2,
    OP_STOP   = 3'd3,
    OP_SETOPT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KIND_FIRED   = 2'd0,
    KIND_CREATED = 2'd1,
    KIND_FULL    = 2'd2
  } kind_e;

  localparam int OPT_SEND     = 0;
  localparam int OPT_PERIODIC = 1;
  localparam int OPT_FREE     = 2;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] MAX_RESULTS = 5'd16;

  // One transaction in flight. For a tick, flag/slot hold a fired result that
  // waits until we know whether it is the final one. For a create, they hold
  // the claimed slot.
  typedef struct packed {
    logic             valid;
    logic [2:0]       op;
    logic [3:0]       idx;
    logic [31:0]      period;
    logic [2:0]       opts;
    logic             flag;
    logic [3:0]       slot;
    logic [CNT_W-1:0] cnt;
  } tok_t;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [3:0] slot;
    logic       last;
  } emit_t;

endpackage

// ----- rtl/core/stt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_cell: one timer slot
// Holds the state of one timer, acts on the token as it passes and hands the
// token to the next cell.
// ----------------------------------------------------------------------------
module stt_cell #(
  parameter int SLOT_ID = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic [31:0]   tick_i,
  input  stt_pkg::tok_t tok_i,
  output stt_pkg::tok_t tok_o,
  output stt_pkg::emit_t emit_o
);

  localparam logic [3:0] SlotLow = 4'(SLOT_ID);
  localparam bit Addressable = (SLOT_ID < 16);

  stt_pkg::tok_t tok_d, tok_q;
  logic          alloc_d, alloc_q;
  logic          armed_d, armed_q;
  logic [31:0]   period_d, period_q;
  logic [31:0]   expiry_d, expiry_q;
  logic [2:0]    opts_d, opts_q;

  logic        sel;
  logic        hit;
  logic        fire;
  logic        claim;
  logic [31:0] rearm;

  assign sel   = Addressable && (tok_i.idx == SlotLow);
  assign rearm = tick_i + period_q;
  assign hit   = tok_i.valid && (tok_i.op == stt_pkg::OP_TICK) && alloc_q && armed_q &&
                 (expiry_q == tick_i);
  assign fire  = hit && opts_q[stt_pkg::OPT_SEND] && (tok_i.cnt < stt_pkg::MAX_RESULTS);
  assign claim = tok_i.valid && (tok_i.op == stt_pkg::OP_CREATE) && !tok_i.flag && !alloc_q;

  always_comb begin
    tok_d = tok_i;
    if (fire || claim) begin
      tok_d.flag = 1'b1;
      tok_d.slot = SlotLow;
    end
    if (fire) begin
      tok_d.cnt = tok_i.cnt + 1'b1;
    end
  end

  // A new fired result pushes out the one held in the token, which therefore
  // cannot be the final result.
  always_comb begin
    emit_o       = '0;
    emit_o.valid = fire && tok_i.flag;
    emit_o.kind  = stt_pkg::KIND_FIRED;
    emit_o.slot  = tok_i.slot;
    emit_o.last  = 1'b0;
  end

  always_comb begin
    alloc_d  = alloc_q;
    armed_d  = armed_q;
    period_d = period_q;
    expiry_d = expiry_q;
    opts_d   = opts_q;
    if (hit) begin
      armed_d = 1'b0;
      if (opts_q[stt_pkg::OPT_PERIODIC]) begin
        expiry_d = rearm;
        armed_d  = 1'b1;
      end else if (opts_q[stt_pkg::OPT_FREE]) begin
        alloc_d = 1'b0;
      end
    end
    if (claim) begin
      alloc_d  = 1'b1;
      armed_d  = 1'b0;
      period_d = tok_i.period;
      opts_d   = tok_i.opts;
    end
    if (tok_i.valid && sel) begin
      if ((tok_i.op == stt_pkg::OP_START) && alloc_q) begin
        expiry_d = rearm;
        armed_d  = 1'b1;
      end
      if (tok_i.op == stt_pkg::OP_STOP) begin
        armed_d = 1'b0;
        alloc_d = 1'b0;
      end
      if ((tok_i.op == stt_pkg::OP_SETOPT) && alloc_q) begin
        opts_d = tok_i.opts;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= '0;
      alloc_q <= 1'b0;
      armed_q <= 1'b0;
    end else if (adv_i) begin
      tok_q   <= tok_d;
      alloc_q <= alloc_d;
      armed_q <= armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      period_q <= period_d;
      expiry_q <= expiry_d;
      opts_q   <= opts_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/core/stt_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_out_stage: result collection and output register
// Gathers the result of the active cell or of the chain tail, registers it
// toward the output and freezes the chain while a result waits on a full, stalled output.
// ----------------------------------------------------------------------------
module stt_out_stage #(
  parameter int TIMER_COUNT = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  stt_pkg::emit_t cell_emit_i [TIMER_COUNT],
  input  stt_pkg::tok_t  tail_i,
  input  logic [31:0]    tick_i,
  output logic           adv_o,
  output logic           done_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     kind_o,
  output logic [3:0]     slot_o,
  output logic [31:0]    fire_time_o,
  output logic           last_o
);

  stt_pkg::emit_t cell_sel;
  stt_pkg::emit_t tail_emit;
  stt_pkg::emit_t src;
  logic           out_free;

  logic           out_valid_d, out_valid_q;
  stt_pkg::emit_t res_q;
  logic [31:0]    time_q;

  // Only the cell holding the token can emit, so an OR picks it out.
  always_comb begin
    cell_sel = '0;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      cell_sel = stt_pkg::emit_t'(cell_sel | cell_emit_i[i]);
    end
  end

  always_comb begin
    tail_emit      = '0;
    tail_emit.last = 1'b1;
    tail_emit.kind = stt_pkg::KIND_FIRED;
    if (tail_i.valid && (tail_i.op == stt_pkg::OP_TICK) && tail_i.flag) begin
      tail_emit.valid = 1'b1;
      tail_emit.slot  = tail_i.slot;
    end
    if (tail_i.valid && (tail_i.op == stt_pkg::OP_CREATE)) begin
      tail_emit.valid = 1'b1;
      tail_emit.kind  = tail_i.flag ? stt_pkg::KIND_CREATED : stt_pkg::KIND_FULL;
      tail_emit.slot  = tail_i.flag ? tail_i.slot : 4'd0;
    end
  end

  assign src      = cell_sel.valid ? cell_sel : tail_emit;
  assign out_free = !out_valid_q || !out_stall_i;
  assign adv_o    = !src.valid || out_free;
  assign done_o   = tail_i.valid && adv_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (src.valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (src.valid && out_free) begin
      res_q  <= src;
      time_q <= tick_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign slot_o      = res_q.slot;
  assign fire_time_o = time_q;
  assign last_o      = res_q.last;

endmodule

// ----- rtl/core/software_timer_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// software_timer_table: pool of tick-driven timers
// A row of timer cells; each transaction travels down the row as a token and
// every cell acts on it for its own slot.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+--------------------------
//   in      | input     | in_valid_i / in_stall_o  | operation, timer_index,
//           |           |                          | period, options
//   out     | output    | out_valid_o / out_stall_i| kind, slot, fire_time, last
//
// One transaction is in flight at a time: it passes through the entry
// register and then the register of each of the TIMER_COUNT cells, and a new
// one is taken only after the previous one has left the last cell.
// While the output register stays full and a stalled result waits, the whole
// row holds still.
// Reset frees and disarms every slot and clears the tick count; slot period
// and options hold garbage until a create writes them, expiry until a start.
// ----------------------------------------------------------------------------
module software_timer_table #(
  parameter int TIMER_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  timer_index_i,
  input  logic [31:0] period_i,
  input  logic [2:0]  options_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [31:0] fire_time_o,
  output logic        last_o
);

  logic          accept;
  logic          adv;
  logic          done;
  logic          busy_d, busy_q;
  logic [31:0]   tick_d, tick_q;
  stt_pkg::tok_t entry_d, entry_q;

  stt_pkg::tok_t  tok [TIMER_COUNT];
  stt_pkg::emit_t emit [TIMER_COUNT];

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (done) begin
      busy_d = 1'b0;
    end
  end

  assign tick_d = (accept && (operation_i == stt_pkg::OP_TICK)) ? tick_q + 32'd1 : tick_q;

  always_comb begin
    entry_d = entry_q;
    if (accept) begin
      entry_d        = '0;
      entry_d.valid  = 1'b1;
      entry_d.op     = operation_i;
      entry_d.idx    = timer_index_i;
      entry_d.period = period_i;
      entry_d.opts   = options_i;
    end else if (adv) begin
      entry_d.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      tick_q  <= '0;
      entry_q <= '0;
    end else begin
      busy_q  <= busy_d;
      tick_q  <= tick_d;
      entry_q <= entry_d;
    end
  end

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
    stt_pkg::tok_t tok_in;
    if (i == 0) begin : g_head
      assign tok_in = entry_q;
    end else begin : g_link
      assign tok_in = tok[i-1];
    end
    stt_cell #(
      .SLOT_ID(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tick_i(tick_q),
      .tok_i (tok_in),
      .tok_o (tok[i]),
      .emit_o(emit[i])
    );
  end

  stt_out_stage #(
    .TIMER_COUNT(TIMER_COUNT)
  ) u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cell_emit_i(emit),
    .tail_i     (tok[TIMER_COUNT-1]),
    .tick_i     (tick_q),
    .adv_o      (adv),
    .done_o     (done),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .slot_o     (slot_o),
    .fire_time_o(fire_time_o),
    .last_o     (last_o)
  );

endmodule

// ----- rtl/core/stt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_checker: port-level checks of the software timer table
// Watches the ports of the top level; attached by the bind below.
// ----------------------------------------------------------------------------
module stt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic [3:0]  slot_o,
  input logic [31:0] fire_time_o,
  input logic        last_o
);

  // A result that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(slot_o) &&
      $stable(fire_time_o) && $stable(last_o))
    else $error("stalled result changed");

  // Only one transaction is in flight: after an accept the input is closed.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while one is in flight");

  // A create gives exactly one result, which is therefore the final one.
  a_create_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != stt_pkg::KIND_FIRED) |-> last_o)
    else $error("create result not marked final");

  // A full pool reports slot zero.
  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == stt_pkg::KIND_FULL) |-> (slot_o == 4'd0))
    else $error("pool full result with nonzero slot");

endmodule

bind software_timer_table stt_checker u_stt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .kind_o     (kind_o),
  .slot_o     (slot_o),
  .fire_time_o(fire_time_o),
  .last_o     (last_o)
);

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the software timer table
// Drives tick, create, start, stop and set-options transactions through the
// input channel, predicts every fired, created and pool-full result with a
// model of the timer pool, and checks each result in order on the output
// channel. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int TIMER_COUNT = 16;
  localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;
  localparam int ITEM_BUDGET = 310;

  typedef struct {
    stt_pkg::kind_e kind;
    logic [3:0]     slot;
    logic [31:0]    fire_time;
    logic           last;
  } timer_event_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  operation_i;
  logic [3:0]  timer_index_i;
  logic [31:0] period_i;
  logic [2:0]  options_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [3:0]  slot_o;
  logic [31:0] fire_time_o;
  logic        last_o;

  // Shadow copy of the timer pool.
  logic [31:0] pool_tick;
  logic        pool_live   [TIMER_COUNT];
  logic        pool_armed  [TIMER_COUNT];
  logic [31:0] pool_period [TIMER_COUNT];
  logic [31:0] pool_expiry [TIMER_COUNT];
  logic [2:0]  pool_opts   [TIMER_COUNT];
  int          last_created;

  timer_event_t pending_timer_events[$];
  int mismatches;
  int items_sent;
  int burst_left;
  bit no_gaps;

  software_timer_table #(
    .TIMER_COUNT(TIMER_COUNT)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .timer_index_i(timer_index_i),
    .period_i     (period_i),
    .options_i    (options_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .slot_o       (slot_o),
    .fire_time_o  (fire_time_o),
    .last_o       (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic void push_event(stt_pkg::kind_e kind, int slot, logic last);
    timer_event_t ev;
    ev.kind      = kind;
    ev.slot      = 4'(slot);
    ev.fire_time = pool_tick;
    ev.last      = last;
    pending_timer_events.push_back(ev);
  endfunction

  // Applies one accepted transaction to the shadow pool and queues its results.
  function automatic void advance_timer_pool(logic [2:0] op, logic [3:0] idx,
                                             logic [31:0] period, logic [2:0] opts);
    int fired[$];
    int found;
    found = -1;
    case (op)
      stt_pkg::OP_TICK: begin
        pool_tick = pool_tick + 32'd1;
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (pool_live[i] && pool_armed[i] && pool_expiry[i] == pool_tick) begin
            pool_armed[i] = 1'b0;
            if (pool_opts[i][stt_pkg::OPT_SEND] &&
                fired.size() < int'(stt_pkg::MAX_RESULTS))
              fired.push_back(i);
            if (pool_opts[i][stt_pkg::OPT_PERIODIC]) begin
              pool_expiry[i] = pool_tick + pool_period[i];
              pool_armed[i]  = 1'b1;
            end else if (pool_opts[i][stt_pkg::OPT_FREE]) begin
              pool_live[i] = 1'b0;
            end
          end
        end
        foreach (fired[k])
          push_event(stt_pkg::KIND_FIRED, fired[k], k == fired.size() - 1);
      end
      stt_pkg::OP_CREATE: begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
          if (found < 0 && !pool_live[i]) found = i;
        end
        last_created = found;
        if (found >= 0) begin
          pool_live[found]   = 1'b1;
          pool_armed[found]  = 1'b0;
          pool_period[found] = period;
          pool_opts[found]   = opts;
          pool_expiry[found] = '0;
          push_event(stt_pkg::KIND_CREATED, found, 1'b1);
        end else begin
          push_event(stt_pkg::KIND_FULL, 0, 1'b1);
        end
      end
      stt_pkg::OP_START: begin
        if (int'(idx) < TIMER_COUNT && pool_live[idx]) begin
          pool_expiry[idx] = pool_tick + pool_period[idx];
          pool_armed[idx]  = 1'b1;
        end
      end
      stt_pkg::OP_STOP: begin
        if (int'(idx) < TIMER_COUNT) begin
          pool_armed[idx] = 1'b0;
          pool_live[idx]  = 1'b0;
        end
      end
      stt_pkg::OP_SETOPT: begin
        if (int'(idx) < TIMER_COUNT && pool_live[idx]) pool_opts[idx] = opts;
      end
      default: ;
    endcase
  endfunction

  // Sends one transaction, opening a random gap at the start of each burst.
  task automatic send_item(input logic [2:0] op, input logic [3:0] idx,
                           input logic [31:0] period, input logic [2:0] opts);
    int gap;
    @(negedge clk_i);
    if (burst_left <= 0) begin
      gap = no_gaps ? 0 : $urandom_range(1, 24);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    timer_index_i <= idx;
    period_i      <= period;
    options_i     <= opts;
    do @(posedge clk_i); while (in_stall_o);
    advance_timer_pool(op, idx, period, opts);
    if (op < OP_RESERVED_FIRST) items_sent++;
  endtask

  function automatic logic [3:0] rand_idx();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [2:0] rand_opts();
    return 3'($urandom_range(0, 7));
  endfunction

  // Mostly short periods so that timers expire within a few ticks.
  function automatic logic [31:0] rand_period();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 32'd0;
    if (pick < 12) return $urandom;
    return 32'($urandom_range(1, 6));
  endfunction

  task automatic send_tick();
    send_item(stt_pkg::OP_TICK, rand_idx(), $urandom, rand_opts());
  endtask

  task automatic send_to_slot(input logic [2:0] op, input logic [3:0] idx,
                              input logic [2:0] opts);
    send_item(op, idx, $urandom, opts);
  endtask

  // Holds the sender until every queued result has come out.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_timer_events.size() != 0) @(posedge clk_i);
    repeat (TIMER_COUNT + 4) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic test_ignored_operations();
    for (int op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST; op++)
      send_item(3'(op), rand_idx(), $urandom, rand_opts());
    send_tick();
    // Start, set options and stop on a slot that was never created.
    send_to_slot(stt_pkg::OP_START, 4'd2, rand_opts());
    send_to_slot(stt_pkg::OP_SETOPT, 4'd2, 3'd7);
    send_to_slot(stt_pkg::OP_STOP, 4'd15, rand_opts());
  endtask

  task automatic test_create_and_fire();
    send_item(stt_pkg::OP_CREATE, 4'd0, 32'hFFFF_FFFF, 3'd7);
    send_item(stt_pkg::OP_CREATE, 4'd15, 32'd1, 3'(1 << stt_pkg::OPT_SEND));
    send_to_slot(stt_pkg::OP_START, 4'd1, 3'd0);
    send_tick();
  endtask

  task automatic test_restart_and_stop();
    send_to_slot(stt_pkg::OP_START, 4'd1, 3'd0);
    send_tick();
    // A second start re-arms from the current time.
    send_to_slot(stt_pkg::OP_START, 4'd1, 3'd0);
    send_tick();
    send_to_slot(stt_pkg::OP_STOP, 4'd1, 3'd0);
    send_to_slot(stt_pkg::OP_STOP, 4'd1, 3'd0);
  endtask

  task automatic test_zero_period();
    send_item(stt_pkg::OP_CREATE, 4'd0, 32'd0,
              3'((1 << stt_pkg::OPT_SEND) | (1 << stt_pkg::OPT_PERIODIC)));
    send_to_slot(stt_pkg::OP_START, 4'd1, 3'd0);
    send_tick();
    send_to_slot(stt_pkg::OP_SETOPT, 4'd0, 3'd0);
    send_to_slot(stt_pkg::OP_START, 4'd0, 3'd0);
    send_to_slot(stt_pkg::OP_STOP, 4'd0, 3'd0);
    send_to_slot(stt_pkg::OP_STOP, 4'd1, 3'd0);
  endtask

  // Fills the pool, arms every timer close together, ticks one to four times and stops every slot.
  task automatic test_all_timers_expire();
    int tries;
    tries = 0;
    do begin
      send_item(stt_pkg::OP_CREATE, rand_idx(), 32'($urandom_range(1, 2)),
                rand_opts() | 3'(1 << stt_pkg::OPT_SEND));
      tries++;
    end while (last_created >= 0 && tries <= TIMER_COUNT);
    for (int i = 0; i < TIMER_COUNT; i++)
      if (pool_live[i]) send_to_slot(stt_pkg::OP_START, 4'(i), rand_opts());
    repeat ($urandom_range(1, 4)) send_tick();
    for (int i = 0; i < TIMER_COUNT; i++)
      send_to_slot(stt_pkg::OP_STOP, 4'(i), rand_opts());
  endtask

  task automatic run_timer_life();
    int s;
    send_item(stt_pkg::OP_CREATE, rand_idx(), rand_period(), rand_opts());
    s = last_created;
    if (s < 0) begin
      send_to_slot(stt_pkg::OP_STOP, rand_idx(), rand_opts());
      return;
    end
    send_to_slot(stt_pkg::OP_START, 4'(s), rand_opts());
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0: send_to_slot(stt_pkg::OP_START, 4'(s), rand_opts());
        1: send_to_slot(stt_pkg::OP_SETOPT, 4'(s), rand_opts());
        default: send_tick();
      endcase
    end
    if ($urandom_range(0, 2) == 0) send_to_slot(stt_pkg::OP_STOP, 4'(s), rand_opts());
  endtask

  task automatic test_random_traffic(input int budget);
    int pick;
    while (items_sent < budget) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        run_timer_life();
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 10)) send_tick();
      end else if (pick < 78) begin
        repeat ($urandom_range(1, 6))
          send_item(3'($urandom_range(0, 7)), rand_idx(), $urandom, rand_opts());
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4))
          send_to_slot(stt_pkg::OP_STOP, rand_idx(), rand_opts());
      end else if (pick < 95) begin
        test_all_timers_expire();
      end else begin
        drain_results();
      end
    end
  endtask

  // Receiver: stretches of no stall, light, even and heavy stalling.
  initial begin
    int mode;
    int len;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 150);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    timer_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_timer_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d slot=%0d time=%0d last=%0b",
                                  kind_o, slot_o, fire_time_o, last_o));
      end else begin
        want = pending_timer_events.pop_front();
        if (kind_o !== want.kind || slot_o !== want.slot ||
            fire_time_o !== want.fire_time || last_o !== want.last)
          report_mismatch($sformatf(
              "got kind=%0d slot=%0d time=%0d last=%0b, want %0d %0d %0d %0b",
              kind_o, slot_o, fire_time_o, last_o,
              want.kind, want.slot, want.fire_time, want.last));
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    operation_i   = '0;
    timer_index_i = '0;
    period_i      = '0;
    options_i     = '0;
    pool_tick     = '0;
    last_created  = -1;
    mismatches    = 0;
    items_sent    = 0;
    burst_left    = 0;
    no_gaps       = 1'b0;
    for (int i = 0; i < TIMER_COUNT; i++) begin
      pool_live[i]   = 1'b0;
      pool_armed[i]  = 1'b0;
      pool_period[i] = '0;
      pool_expiry[i] = '0;
      pool_opts[i]   = '0;
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ignored_operations();
    test_create_and_fire();
    test_restart_and_stop();
    test_zero_period();
    drain_results();
    test_all_timers_expire();
    test_random_traffic(ITEM_BUDGET);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_timer_events.size() != 0) @(posedge clk_i);
    repeat (4 * TIMER_COUNT) @(posedge clk_i);
    if (mismatches == 0 && pending_timer_events.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/stt_pkg.sv
rtl/core/stt_cell.sv
rtl/core/stt_out_stage.sv
rtl/core/software_timer_table.sv
rtl/core/stt_checker.sv
test/testbench.sv
